// ===== rtl/bvst_pkg.sv =====
package bvst_pkg;

    // Default sizes
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int REQ_W       = 2;
    localparam int ST_W        = 2;
    localparam int CAP_W       = 5;
    localparam int COUNT_OUT_W = 5;

    // Config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds (kind 3 is a no-op)
    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHK = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Controller -> datapath
    typedef struct packed {
        logic    load;
        logic    do_add;
        logic    start_search;
        logic    step_search;
        logic    start_shift;
        logic    step_shift;
        logic    dec_count;
        logic    set_res;
        status_t res_status;
        logic    res_found;
        logic    emit;
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             count_zero;
        logic             add_full;
        logic             hit;
        logic             miss;
        logic             shift_done;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== rtl/bvst_ram.sv =====
module bvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bvst_datapath.sv =====
module bvst_datapath #(
    parameter int DEPTH       = bvst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bvst_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bvst_pkg::ctl_cmd_t              cmd,
    output bvst_pkg::dp_stat_t              stat,
    input  logic [bvst_pkg::CAP_W-1:0]      cap,
    input  logic [bvst_pkg::REQ_W-1:0]      in_req,
    input  logic [VALUE_WIDTH-1:0]          in_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bvst_pkg::status_t               out_status,
    output logic                            out_found,
    output logic [bvst_pkg::COUNT_OUT_W-1:0] out_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = (CW > bvst_pkg::CAP_W) ? CW : bvst_pkg::CAP_W;

    logic [bvst_pkg::REQ_W-1:0] req_reg;
    logic [VALUE_WIDTH-1:0]     value_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              ptr_reg;
    logic                       pend_vld_reg;
    logic [CW-1:0]              pend_idx_reg;
    bvst_pkg::status_t          res_status_reg;
    logic                       res_found_reg;
    logic                       out_vld_reg;
    bvst_pkg::status_t          out_status_reg;
    logic                       out_found_reg;
    logic [bvst_pkg::COUNT_OUT_W-1:0] out_count_reg;

    logic [MW-1:0]          cap_ext;
    logic [MW-1:0]          eff_cap;
    logic [MW-1:0]          count_ext;
    logic                   ptr_lt_count;
    logic [CW-1:0]          pend_prev;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // capacity saturates at DEPTH
    assign cap_ext   = MW'(cap);
    assign eff_cap   = (cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : cap_ext;
    assign count_ext = MW'(count_reg);

    assign ptr_lt_count = ptr_reg < count_reg;
    assign pend_prev    = pend_idx_reg - CW'(1);

    // add appends at count; shift moves slot i+1 down to slot i
    assign ram_we    = cmd.do_add || (cmd.step_shift && pend_vld_reg);
    assign ram_waddr = cmd.do_add ? count_reg[AW-1:0] : pend_prev[AW-1:0];
    assign ram_wdata = cmd.do_add ? value_reg : ram_rdata;

    bvst_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        stat.req_type   = req_reg;
        stat.count_zero = (count_reg == '0);
        stat.add_full   = (count_ext >= eff_cap);
        stat.hit        = pend_vld_reg && (ram_rdata == value_reg);
        stat.miss       = !pend_vld_reg && !ptr_lt_count;
        stat.shift_done = !pend_vld_reg && !ptr_lt_count;
        stat.out_free   = !out_vld_reg || out_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cmd.do_add) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.dec_count) begin
                count_reg <= count_reg - CW'(1);
            end

            if (cmd.start_shift) begin
                ptr_reg      <= pend_idx_reg + CW'(1);
                pend_vld_reg <= 1'b0;
            end else if (cmd.start_search) begin
                ptr_reg      <= '0;
                pend_vld_reg <= 1'b0;
            end else if (cmd.step_search || cmd.step_shift) begin
                if (ptr_lt_count) begin
                    pend_vld_reg <= 1'b1;
                    pend_idx_reg <= ptr_reg;
                    ptr_reg      <= ptr_reg + CW'(1);
                end else begin
                    pend_vld_reg <= 1'b0;
                end
            end

            if (cmd.emit) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= in_req;
            value_reg <= in_value;
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found;
        end
        if (cmd.emit) begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= count_ext[bvst_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== rtl/bvst_ctrl.sv =====
module bvst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bvst_pkg::dp_stat_t stat,
    output bvst_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.set_res    = 1'b1;
                cmd.res_status = bvst_pkg::ST_OK;
                state_next     = S_RESULT;
                case (stat.req_type)
                    bvst_pkg::REQ_ADD: begin
                        if (stat.add_full) begin
                            cmd.res_status = bvst_pkg::ST_FULL;
                        end else begin
                            cmd.do_add = 1'b1;
                        end
                    end
                    bvst_pkg::REQ_DEL: begin
                        if (stat.count_zero) begin
                            cmd.res_status = bvst_pkg::ST_EMPTY;
                        end else begin
                            cmd.set_res      = 1'b0;
                            cmd.start_search = 1'b1;
                            state_next       = S_SEARCH;
                        end
                    end
                    bvst_pkg::REQ_CHK: begin
                        if (!stat.count_zero) begin
                            cmd.set_res      = 1'b0;
                            cmd.start_search = 1'b1;
                            state_next       = S_SEARCH;
                        end
                    end
                    default: begin
                        // unused kind: plain OK, nothing changes
                    end
                endcase
            end
            S_SEARCH: begin
                cmd.step_search = 1'b1;
                if (stat.hit) begin
                    if (stat.req_type == bvst_pkg::REQ_DEL) begin
                        cmd.start_shift = 1'b1;
                        state_next      = S_SHIFT;
                    end else begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = bvst_pkg::ST_OK;
                        cmd.res_found  = 1'b1;
                        state_next     = S_RESULT;
                    end
                end else if (stat.miss) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = (stat.req_type == bvst_pkg::REQ_DEL) ?
                                     bvst_pkg::ST_MISSING : bvst_pkg::ST_OK;
                    state_next     = S_RESULT;
                end
            end
            S_SHIFT: begin
                cmd.step_shift = 1'b1;
                if (stat.shift_done) begin
                    cmd.dec_count  = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_status = bvst_pkg::ST_OK;
                    cmd.res_found  = 1'b1;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/bounded_value_set_table_top.sv =====
// Channel   Dir  Fields (tdata, lowest bit first)                Handshake
// s_        in   req_type[1:0], value[VALUE_WIDTH-1:0], zero pad  tvalid/tready
// m_        out  status[1:0], found, count[4:0]                   tvalid/tready
// apb       in   capacity at byte address 0                       psel/penable, pready=1
//
// Flow of a word: add, kind 3, or delete/check on an empty table go straight to the result;
// check or delete reads slots in order from slot 0 up to the first match (up to count on a
// miss); a delete hit then shifts each later slot down one place through the one-read RAM.
// Reset: synchronous, active low; count to 0, capacity to 16, entry RAM left as is.
// A finished result waits in the m_ output register while the next word is taken
// and worked on; only that word's own result holds on m_tready.
module bounded_value_set_table_top #(
    parameter int DEPTH       = bvst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bvst_pkg::VALUE_WIDTH_DEF,
    localparam int S_TDATA_W  = ((bvst_pkg::REQ_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,   // req_type, value, pad

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // status, found, count

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bvst_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bvst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bvst_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [bvst_pkg::CAP_W-1:0]       cap_reg;
    logic                             cap_sel;
    bvst_pkg::ctl_cmd_t               cmd;
    bvst_pkg::dp_stat_t               stat;
    bvst_pkg::status_t                out_status;
    logic                             out_found;
    logic [bvst_pkg::COUNT_OUT_W-1:0] out_count;

    // Only register 0 exists; byte address 4 and up is ignored.
    assign cap_sel = (paddr[bvst_pkg::APB_ADDR_W-1] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? bvst_pkg::APB_DATA_W'(cap_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bvst_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && cap_sel) begin
            cap_reg <= pwdata[bvst_pkg::CAP_W-1:0];
        end
    end

    bvst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bvst_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cap        (cap_reg),
        .in_req     (s_tdata[bvst_pkg::REQ_W-1:0]),
        .in_value   (s_tdata[bvst_pkg::REQ_W +: VALUE_WIDTH]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_found  (out_found),
        .out_count  (out_count)
    );

    assign m_tdata = {out_count, out_found, out_status};

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int DEPTH          = bvst_pkg::DEPTH_DEF;
    localparam int VW             = bvst_pkg::VALUE_WIDTH_DEF;
    localparam int S_TDATA_W      = ((bvst_pkg::REQ_W + VW + 7) / 8) * 8;
    localparam int ITEM_TARGET    = 1050;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;   // worst search plus shift, with margin
    localparam int LONG_HOLD      = 300;             // receiver hold-off for back-pressure
    localparam int WATCHDOG_LIMIT = 4000;            // cycles with no word moved at all

    // Register map: capacity at index 0, index 1 is unmapped
    localparam logic [bvst_pkg::APB_ADDR_W-1:0] CAP_ADDR   = 3'd0;
    localparam logic [bvst_pkg::APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    // Kind 3 has no name in the package; the block answers it without change
    localparam logic [bvst_pkg::REQ_W-1:0] REQ_NOP = 2'd3;

    typedef struct packed {
        bvst_pkg::status_t status;
        logic              found;
        logic [4:0]        count;
    } table_result_t;

    typedef struct {
        logic                            cfg;     // 1: register write instead of a request
        logic [bvst_pkg::APB_ADDR_W-1:0] addr;
        logic [bvst_pkg::REQ_W-1:0]      kind;
        logic [VW-1:0]                   data;
        logic                            typed;   // expected result given in the row
        table_result_t                   result;
    } step_row_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [S_TDATA_W-1:0]              s_tdata;    // req_type[1:0], value[33:2], zero pad
    logic                              m_tvalid;
    logic                              m_tready;
    logic [7:0]                        m_tdata;    // status[1:0], found[2], count[7:3]
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [bvst_pkg::APB_ADDR_W-1:0]   paddr;
    logic [bvst_pkg::APB_DATA_W-1:0]   pwdata;
    logic [bvst_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    bounded_value_set_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Shadow of the block: packed entries, fill level and capacity register
    logic [VW-1:0]  slots [DEPTH];
    int             held;
    logic [4:0]     cap_shadow;

    table_result_t  pending [$];        // results owed by the block, oldest first
    int             fault_count = 0;
    int             req_total   = 0;    // words of kind add, delete or check sent
    int             burst_left  = 0;
    bit             long_hold_req = 1'b0;

    // Applies one request to the shadow table and returns the word it answers with
    function automatic table_result_t apply_request(input logic [bvst_pkg::REQ_W-1:0] kind,
                                                    input logic [VW-1:0] val);
        table_result_t r;
        int room;
        int hit;
        r.status = bvst_pkg::ST_OK;
        r.found  = 1'b0;
        room = (cap_shadow > DEPTH) ? DEPTH : int'(cap_shadow);
        hit  = held;
        for (int i = held - 1; i >= 0; i--) begin
            if (slots[i] == val) hit = i;
        end
        case (kind)
            bvst_pkg::REQ_ADD: begin
                if (held >= room) begin
                    r.status = bvst_pkg::ST_FULL;
                end else begin
                    slots[held] = val;
                    held++;
                end
            end
            bvst_pkg::REQ_DEL: begin
                if (held == 0) begin
                    r.status = bvst_pkg::ST_EMPTY;
                end else if (hit == held) begin
                    r.status = bvst_pkg::ST_MISSING;
                end else begin
                    r.found = 1'b1;
                    for (int i = hit; i < held - 1; i++) slots[i] = slots[i + 1];
                    held--;
                end
            end
            bvst_pkg::REQ_CHK: r.found = (hit < held);
            default: ;
        endcase
        r.count = held[4:0];
        return r;
    endfunction

    function automatic step_row_t req_row(input logic [bvst_pkg::REQ_W-1:0] kind,
                                          input logic [VW-1:0] val, input logic typed,
                                          input bvst_pkg::status_t st, input logic fnd,
                                          input logic [4:0] cnt);
        step_row_t row;
        row.cfg    = 1'b0;
        row.addr   = CAP_ADDR;
        row.kind   = kind;
        row.data   = val;
        row.typed  = typed;
        row.result = '{status: st, found: fnd, count: cnt};
        return row;
    endfunction

    function automatic step_row_t cfg_row(input logic [bvst_pkg::APB_ADDR_W-1:0] addr,
                                          input logic [VW-1:0] val);
        step_row_t row;
        row = req_row(REQ_NOP, val, 1'b0, bvst_pkg::ST_OK, 1'b0, 5'd0);
        row.cfg  = 1'b1;
        row.addr = addr;
        return row;
    endfunction

    // Offers one word, sometimes after a gap; returns at the edge that takes it,
    // with s_tvalid still high so back-to-back words need no second assignment.
    task automatic issue_request(input logic [bvst_pkg::REQ_W-1:0] kind,
                                 input logic [VW-1:0] val,
                                 input logic typed, input table_result_t given);
        table_result_t r;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - bvst_pkg::REQ_W - VW){1'b0}}, val, kind};
        do @(posedge aclk); while (!s_tready);
        r = apply_request(kind, val);
        pending.push_back(typed ? given : r);
        if (kind != REQ_NOP) req_total++;
    endtask

    // Stop offering, let every owed result come out, then let the block go quiet
    task automatic settle_table();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup then access cycle; the register takes pwdata at the access edge,
    // then the bus goes idle before the next access
    task automatic write_reg(input logic [bvst_pkg::APB_ADDR_W-1:0] addr,
                             input logic [bvst_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAP_ADDR) cap_shadow = data[4:0];
        @(posedge aclk);
    endtask

    // Receiver: stall pattern steps through none, regular, random and sparse as its cycle
    // counter runs, plus one long hold-off on request so the block backs up its input.
    initial begin
        int  rx_cyc;
        int  hold_left;
        logic rdy;
        rx_cyc    = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_cyc++;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            case (rx_cyc[9:8])
                2'd0: rdy = 1'b1;
                2'd1: rdy = (rx_cyc % 3) != 0;
                2'd2: rdy = ($urandom_range(0, 1) != 0);
                default: rdy = ($urandom_range(0, 7) != 0);
            endcase
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end
            m_tready <= rdy;
        end
    end

    // Result checker: values are sampled before the edge updates anything
    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                $display("%0t: result word %h with no result pending", $time, m_tdata);
                fault_count++;
            end else begin
                want = pending.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[1:0]);
                    fault_count++;
                end
                if (m_tdata[2] !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, m_tdata[2]);
                    fault_count++;
                end
                if (m_tdata[7:3] !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, m_tdata[7:3]);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: any moved word or register access restarts the count
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        step_row_t     script [$];
        logic [VW-1:0] pool [8];
        logic [VW-1:0] val;
        logic [bvst_pkg::APB_DATA_W-1:0] wdata;
        logic [bvst_pkg::REQ_W-1:0] kind;
        logic [4:0]    cap;
        int            phase;
        int            add_pct;
        int            pick;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        held       = 0;
        cap_shadow = bvst_pkg::CAP_RESET;
        foreach (slots[i]) slots[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extreme values, duplicates, first-match delete,
        // capacity at count, zero, ignored index, below count, above depth
        script.push_back(req_row(bvst_pkg::REQ_CHK, 32'h0000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd0));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'h0000_0005, 1'b1,
                                 bvst_pkg::ST_EMPTY,   1'b0, 5'd0));
        script.push_back(req_row(REQ_NOP,           32'hFFFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd0));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h8000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd1));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h7FFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd2));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h0000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd3));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd4));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h7FFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd5));
        script.push_back(req_row(bvst_pkg::REQ_CHK, 32'h8000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd5));
        script.push_back(req_row(bvst_pkg::REQ_CHK, 32'h0000_0001, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd5));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'h7FFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd4));
        script.push_back(req_row(bvst_pkg::REQ_CHK, 32'h7FFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd4));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'h0001_2345, 1'b1,
                                 bvst_pkg::ST_MISSING, 1'b0, 5'd4));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'hFFFF_FFFF, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd3));
        script.push_back(req_row(REQ_NOP,           32'h0000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b0, 5'd3));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'h8000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd2));
        script.push_back(cfg_row(CAP_ADDR, 32'd2));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h0000_0001, 1'b1,
                                 bvst_pkg::ST_FULL,    1'b0, 5'd2));
        script.push_back(cfg_row(CAP_ADDR, 32'd0));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h0000_0005, 1'b1,
                                 bvst_pkg::ST_FULL,    1'b0, 5'd2));
        script.push_back(cfg_row(SPARE_ADDR, 32'd20));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h0000_0005, 1'b1,
                                 bvst_pkg::ST_FULL,    1'b0, 5'd2));
        script.push_back(cfg_row(CAP_ADDR, 32'd1));
        script.push_back(req_row(bvst_pkg::REQ_DEL, 32'h0000_0000, 1'b1,
                                 bvst_pkg::ST_OK,      1'b1, 5'd1));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h0000_0009, 1'b1,
                                 bvst_pkg::ST_FULL,    1'b0, 5'd1));
        script.push_back(cfg_row(CAP_ADDR, 32'd31));
        script.push_back(req_row(bvst_pkg::REQ_CHK, 32'h7FFF_FFFF, 1'b0,
                                 bvst_pkg::ST_OK,      1'b0, 5'd0));
        script.push_back(req_row(bvst_pkg::REQ_ADD, 32'h55AA_55AA, 1'b0,
                                 bvst_pkg::ST_OK,      1'b0, 5'd0));

        foreach (script[i]) begin
            if (script[i].cfg) begin
                settle_table();
                write_reg(script[i].addr, script[i].data);
            end else begin
                issue_request(script[i].kind, script[i].data, script[i].typed,
                              script[i].result);
            end
        end

        // Random phases: values mostly from a small drifting pool so deletes
        // and checks hit; capacity and add/remove balance change per phase.
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++) pool[i] = $urandom;
        phase = 0;
        while (req_total < ITEM_TARGET) begin
            settle_table();
            case (phase)
                0: cap = 5'd31;
                1: cap = 5'd16;
                2: cap = 5'd0;
                3: cap = 5'd1;
                4: cap = 5'd20;
                5: cap = 5'd15;
                default: cap = 5'($urandom_range(0, 31));
            endcase
            wdata      = $urandom;
            wdata[4:0] = cap;
            write_reg(CAP_ADDR, wdata);
            if ($urandom_range(0, 4) == 0) write_reg(SPARE_ADDR, $urandom);
            add_pct = (phase < 2) ? 85 : $urandom_range(15, 85);
            if (phase >= 4) begin
                pool[$urandom_range(0, 7)] = $urandom;
                pool[$urandom_range(0, 7)] = $urandom;
            end
            if (phase == 2) long_hold_req = 1'b1;
            repeat ($urandom_range(30, 90)) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    kind = REQ_NOP;
                end else if (pick < 3 + add_pct) begin
                    kind = bvst_pkg::REQ_ADD;
                end else begin
                    kind = $urandom_range(0, 1) ? bvst_pkg::REQ_DEL : bvst_pkg::REQ_CHK;
                end
                val = ($urandom_range(0, 4) == 0) ? VW'($urandom) : pool[$urandom_range(0, 7)];
                issue_request(kind, val, 1'b0, '0);
            end
            phase++;
        end

        settle_table();
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
